// ===== rtl/core/rso_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rso_pkg
// Shared types and constants of the rectangle set operations unit.
// ----------------------------------------------------------------------------
package rso_pkg;

   // Default coordinate width of every rectangle corner and point.
   localparam int COORD_WIDTH_DEFAULT = 32;

   // Width of the operation code field.
   localparam int OP_WIDTH = 3;

   // Operation codes. Codes 6 and 7 are unused and give an all-zero result.
   typedef enum logic [OP_WIDTH-1:0] {
      OP_NORMALIZE      = 3'd0,
      OP_UNION          = 3'd1,
      OP_INTERSECT      = 3'd2,
      OP_INTERSECTS     = 3'd3,
      OP_CONTAINS_RECT  = 3'd4,
      OP_CONTAINS_POINT = 3'd5
   } rso_op_type;

endpackage

// ===== rtl/core/rso_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rso_req_if
// Request channel: operation, proper flag and two rectangles (or a point).
// ----------------------------------------------------------------------------
interface rso_req_if #(
   parameter int COORD_WIDTH = rso_pkg::COORD_WIDTH_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic [rso_pkg::OP_WIDTH-1:0]  op;
   logic                          proper;
   logic signed [COORD_WIDTH-1:0] a_left;
   logic signed [COORD_WIDTH-1:0] a_top;
   logic signed [COORD_WIDTH-1:0] a_right;
   logic signed [COORD_WIDTH-1:0] a_bottom;
   logic signed [COORD_WIDTH-1:0] b_left;
   logic signed [COORD_WIDTH-1:0] b_top;
   logic signed [COORD_WIDTH-1:0] b_right;
   logic signed [COORD_WIDTH-1:0] b_bottom;

   modport source (
      output valid, op, proper, a_left, a_top, a_right, a_bottom,
             b_left, b_top, b_right, b_bottom,
      input  ready
   );

   modport sink (
      input  valid, op, proper, a_left, a_top, a_right, a_bottom,
             b_left, b_top, b_right, b_bottom,
      output ready
   );
endinterface

// ===== rtl/core/rso_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rso_rsp_if
// Response channel: result rectangle and boolean answer.
// ----------------------------------------------------------------------------
interface rso_rsp_if #(
   parameter int COORD_WIDTH = rso_pkg::COORD_WIDTH_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] res_left;
   logic signed [COORD_WIDTH-1:0] res_top;
   logic signed [COORD_WIDTH-1:0] res_right;
   logic signed [COORD_WIDTH-1:0] res_bottom;
   logic                          answer;

   modport source (
      output valid, res_left, res_top, res_right, res_bottom, answer,
      input  ready
   );

   modport sink (
      input  valid, res_left, res_top, res_right, res_bottom, answer,
      output ready
   );
endinterface

// ===== rtl/core/rso_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rso_in_stage
// Input register: captures one request transfer per cycle and holds it
// until the next stage takes it.
// ----------------------------------------------------------------------------
module rso_in_stage #(
   parameter int COORD_WIDTH = rso_pkg::COORD_WIDTH_DEFAULT
) (
   input logic  clock,
   input logic  reset,
   rso_req_if.sink   req_bus,
   rso_req_if.source stage_bus
);
   import rso_pkg::*;

   logic                          valid_ff, valid_in;
   logic [OP_WIDTH-1:0]           op_ff;
   logic                          proper_ff;
   logic signed [COORD_WIDTH-1:0] a_left_ff, a_top_ff, a_right_ff, a_bottom_ff;
   logic signed [COORD_WIDTH-1:0] b_left_ff, b_top_ff, b_right_ff, b_bottom_ff;
   logic                          take;

   // The register takes a new item when empty or when its item moves on.
   assign req_bus.ready = !valid_ff || stage_bus.ready;
   assign take          = req_bus.valid && req_bus.ready;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (stage_bus.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // Valid bit is reset; payload is loaded on each transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         op_ff       <= req_bus.op;
         proper_ff   <= req_bus.proper;
         a_left_ff   <= req_bus.a_left;
         a_top_ff    <= req_bus.a_top;
         a_right_ff  <= req_bus.a_right;
         a_bottom_ff <= req_bus.a_bottom;
         b_left_ff   <= req_bus.b_left;
         b_top_ff    <= req_bus.b_top;
         b_right_ff  <= req_bus.b_right;
         b_bottom_ff <= req_bus.b_bottom;
      end
   end

   assign stage_bus.valid    = valid_ff;
   assign stage_bus.op       = op_ff;
   assign stage_bus.proper   = proper_ff;
   assign stage_bus.a_left   = a_left_ff;
   assign stage_bus.a_top    = a_top_ff;
   assign stage_bus.a_right  = a_right_ff;
   assign stage_bus.a_bottom = a_bottom_ff;
   assign stage_bus.b_left   = b_left_ff;
   assign stage_bus.b_top    = b_top_ff;
   assign stage_bus.b_right  = b_right_ff;
   assign stage_bus.b_bottom = b_bottom_ff;

endmodule

// ===== rtl/core/rso_calc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rso_calc
// Combinational rectangle operator: normalize, union, intersect, intersects,
// contains rectangle and contains point.
// ----------------------------------------------------------------------------
module rso_calc #(
   parameter int COORD_WIDTH = rso_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic [rso_pkg::OP_WIDTH-1:0]  op,
   input  logic                          proper,
   input  logic signed [COORD_WIDTH-1:0] a_left,
   input  logic signed [COORD_WIDTH-1:0] a_top,
   input  logic signed [COORD_WIDTH-1:0] a_right,
   input  logic signed [COORD_WIDTH-1:0] a_bottom,
   input  logic signed [COORD_WIDTH-1:0] b_left,
   input  logic signed [COORD_WIDTH-1:0] b_top,
   input  logic signed [COORD_WIDTH-1:0] b_right,
   input  logic signed [COORD_WIDTH-1:0] b_bottom,
   output logic signed [COORD_WIDTH-1:0] res_left,
   output logic signed [COORD_WIDTH-1:0] res_top,
   output logic signed [COORD_WIDTH-1:0] res_right,
   output logic signed [COORD_WIDTH-1:0] res_bottom,
   output logic                          answer
);
   import rso_pkg::*;

   localparam logic signed [COORD_WIDTH-1:0] ONE       = COORD_WIDTH'(1);
   localparam logic signed [COORD_WIDTH-1:0] ZERO      = '0;
   localparam logic signed [COORD_WIDTH-1:0] MINUS_ONE = '1;

   // Wrapped first-minus-one values for the null and normalize tests.
   logic signed [COORD_WIDTH-1:0] al_m1, at_m1, bl_m1, bt_m1;
   // Wrapped extents (second - first + 1) for the span flip test.
   logic signed [COORD_WIDTH-1:0] ax_ext, ay_ext, bx_ext, by_ext;
   logic null_a, null_b;
   logic flip_ax, flip_ay, flip_bx, flip_by;
   logic norm_ax, norm_ay;
   // Ordered spans of both rectangles.
   logic signed [COORD_WIDTH-1:0] l1, r1, t1, b1, l2, r2, t2, b2;
   // Ordered spans of A by the normalize test, used for normalize and the point test.
   logic signed [COORD_WIDTH-1:0] nl, nr, nt, nb;
   logic disjoint, contains_rect, contains_point;
   logic in_x, in_y;

   assign al_m1 = a_left - ONE;
   assign at_m1 = a_top  - ONE;
   assign bl_m1 = b_left - ONE;
   assign bt_m1 = b_top  - ONE;

   assign null_a = (a_right == al_m1) && (a_bottom == at_m1);
   assign null_b = (b_right == bl_m1) && (b_bottom == bt_m1);

   assign ax_ext = a_right  - a_left + ONE;
   assign ay_ext = a_bottom - a_top  + ONE;
   assign bx_ext = b_right  - b_left + ONE;
   assign by_ext = b_bottom - b_top  + ONE;

   assign flip_ax = ax_ext[COORD_WIDTH-1];
   assign flip_ay = ay_ext[COORD_WIDTH-1];
   assign flip_bx = bx_ext[COORD_WIDTH-1];
   assign flip_by = by_ext[COORD_WIDTH-1];

   // Spans used by union, intersect and the rectangle tests.
   assign l1 = flip_ax ? a_right  : a_left;
   assign r1 = flip_ax ? a_left   : a_right;
   assign t1 = flip_ay ? a_bottom : a_top;
   assign b1 = flip_ay ? a_top    : a_bottom;
   assign l2 = flip_bx ? b_right  : b_left;
   assign r2 = flip_bx ? b_left   : b_right;
   assign t2 = flip_by ? b_bottom : b_top;
   assign b2 = flip_by ? b_top    : b_bottom;

   // Normalize and contains-point flip when second is below first minus one.
   assign norm_ax = a_right  < al_m1;
   assign norm_ay = a_bottom < at_m1;
   assign nl = norm_ax ? a_right  : a_left;
   assign nr = norm_ax ? a_left   : a_right;
   assign nt = norm_ay ? a_bottom : a_top;
   assign nb = norm_ay ? a_top    : a_bottom;

   assign disjoint = (r2 < l1) || (r1 < l2) || (b2 < t1) || (b1 < t2);

   assign contains_rect = proper ?
      ((l1 < l2) && (r2 < r1) && (t1 < t2) && (b2 < b1)) :
      (!(l2 < l1) && !(r1 < r2) && !(t2 < t1) && !(b1 < b2));

   // The point sits in b_left and b_top; no null check applies here.
   assign in_x = proper ? ((nl < b_left) && (b_left < nr)) :
                          (!(b_left < nl) && !(nr < b_left));
   assign in_y = proper ? ((nt < b_top) && (b_top < nb)) :
                          (!(b_top < nt) && !(nb < b_top));
   assign contains_point = in_x && in_y;

   // Result selection by operation.
   always_comb begin
      res_left   = ZERO;
      res_top    = ZERO;
      res_right  = ZERO;
      res_bottom = ZERO;
      answer     = 1'b0;
      case (rso_op_type'(op))
         OP_NORMALIZE: begin
            res_left   = nl;
            res_top    = nt;
            res_right  = nr;
            res_bottom = nb;
         end
         OP_UNION: begin
            if (null_a) begin
               res_left   = b_left;
               res_top    = b_top;
               res_right  = b_right;
               res_bottom = b_bottom;
            end else if (null_b) begin
               res_left   = a_left;
               res_top    = a_top;
               res_right  = a_right;
               res_bottom = a_bottom;
            end else begin
               res_left   = (l2 < l1) ? l2 : l1;
               res_top    = (t2 < t1) ? t2 : t1;
               res_right  = (r1 < r2) ? r2 : r1;
               res_bottom = (b1 < b2) ? b2 : b1;
            end
         end
         OP_INTERSECT: begin
            if (null_a || null_b || disjoint) begin
               res_right  = MINUS_ONE;
               res_bottom = MINUS_ONE;
            end else begin
               res_left   = (l1 < l2) ? l2 : l1;
               res_top    = (t1 < t2) ? t2 : t1;
               res_right  = (r2 < r1) ? r2 : r1;
               res_bottom = (b2 < b1) ? b2 : b1;
            end
         end
         OP_INTERSECTS: begin
            answer = !null_a && !null_b && !disjoint;
         end
         OP_CONTAINS_RECT: begin
            answer = !null_a && !null_b && contains_rect;
         end
         OP_CONTAINS_POINT: begin
            answer = contains_point;
         end
         default: begin
            answer = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/core/rso_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rso_out_stage
// Result register: computes the operation on the held request and keeps
// the result until the receiver takes it.
// ----------------------------------------------------------------------------
module rso_out_stage #(
   parameter int COORD_WIDTH = rso_pkg::COORD_WIDTH_DEFAULT
) (
   input logic  clock,
   input logic  reset,
   rso_req_if.sink   stage_bus,
   rso_rsp_if.source rsp_bus
);
   import rso_pkg::*;

   logic                          valid_ff, valid_in;
   logic signed [COORD_WIDTH-1:0] res_left_ff, res_top_ff, res_right_ff, res_bottom_ff;
   logic                          answer_ff;
   logic signed [COORD_WIDTH-1:0] res_left_in, res_top_in, res_right_in, res_bottom_in;
   logic                          answer_in;
   logic                          take;

   rso_calc #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_calc (
      .op         (stage_bus.op),
      .proper     (stage_bus.proper),
      .a_left     (stage_bus.a_left),
      .a_top      (stage_bus.a_top),
      .a_right    (stage_bus.a_right),
      .a_bottom   (stage_bus.a_bottom),
      .b_left     (stage_bus.b_left),
      .b_top      (stage_bus.b_top),
      .b_right    (stage_bus.b_right),
      .b_bottom   (stage_bus.b_bottom),
      .res_left   (res_left_in),
      .res_top    (res_top_in),
      .res_right  (res_right_in),
      .res_bottom (res_bottom_in),
      .answer     (answer_in)
   );

   // A new result loads when the register is empty or being emptied.
   assign stage_bus.ready = !valid_ff || rsp_bus.ready;
   assign take            = stage_bus.valid && stage_bus.ready;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         res_left_ff   <= res_left_in;
         res_top_ff    <= res_top_in;
         res_right_ff  <= res_right_in;
         res_bottom_ff <= res_bottom_in;
         answer_ff     <= answer_in;
      end
   end

   assign rsp_bus.valid      = valid_ff;
   assign rsp_bus.res_left   = res_left_ff;
   assign rsp_bus.res_top    = res_top_ff;
   assign rsp_bus.res_right  = res_right_ff;
   assign rsp_bus.res_bottom = res_bottom_ff;
   assign rsp_bus.answer     = answer_ff;

endmodule

// ===== rtl/core/rectangle_set_ops_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectangle_set_ops_unit
// Axis-aligned rectangle operator on inclusive corner coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one request per transfer: an operation code, the proper
//   flag, rectangle A and rectangle B (or a point in b_left and b_top).
//   rsp_bus returns exactly one result per request, in order: a rectangle
//   for normalize, union and intersect, or the answer bit for the tests.
//   A request transfer loads the input register, then the result register
//   loads from it and shows the result on rsp_bus. The operator logic sits
//   between the two registers, a single pass of subtractors and signed
//   compares. Throughput is one request per cycle while the receiver keeps
//   ready high.
//   Reset empties both registers; no result is shown until a new request.
//   When the receiver holds ready low the result stays put, the input
//   register takes one more request if it is empty, and then req_bus.ready
//   stays low until the receiver takes the waiting result.
// ----------------------------------------------------------------------------
module rectangle_set_ops_unit #(
   parameter int COORD_WIDTH = rso_pkg::COORD_WIDTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   rso_req_if.sink   req_bus,
   rso_rsp_if.source rsp_bus
);
   import rso_pkg::*;

   // Held request between the input register and the result register.
   rso_req_if #(.COORD_WIDTH(COORD_WIDTH)) stage_bus ();

   rso_in_stage #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .stage_bus (stage_bus)
   );

   rso_out_stage #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .stage_bus (stage_bus),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the rectangle set operations unit.
// A queue of pending requests feeds a driver that offers them with random
// gaps, while a receiver takes results with random stalls. Every accepted
// request is run through a local predictor of the rectangle operators, and
// each result transfer is compared field by field against the oldest
// prediction. Directed corner cases come first, then random rectangles.
// ----------------------------------------------------------------------------
module tb;
   import rso_pkg::*;

   localparam int CW = COORD_WIDTH_DEFAULT;
   localparam int IDLE_PCT = 27;
   localparam int RANDOM_ITEMS = 1700;

   // Op codes with no operation behind them.
   localparam logic [OP_WIDTH-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_WIDTH-1:0] OP_SPARE_7 = 3'd7;

   typedef logic signed [CW-1:0] coord_type;

   localparam coord_type COORD_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam coord_type COORD_MAX = {1'b0, {(CW-1){1'b1}}};

   typedef struct {
      logic [OP_WIDTH-1:0] op;
      logic                proper;
      coord_type           a_left, a_top, a_right, a_bottom;
      coord_type           b_left, b_top, b_right, b_bottom;
   } rect_req_type;

   typedef struct {
      coord_type res_left, res_top, res_right, res_bottom;
      logic      answer;
   } rect_rsp_type;

   logic clock;
   logic reset;

   rso_req_if #(.COORD_WIDTH(CW)) req_bus ();
   rso_rsp_if #(.COORD_WIDTH(CW)) rsp_bus ();

   rectangle_set_ops_unit #(.COORD_WIDTH(CW)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   rect_req_type pending_reqs[$];
   rect_rsp_type expected_rsps[$];
   logic         req_taken;
   logic         no_idle;
   bit           failed;
   int           req_count;
   int           hold_cycles;
   bit           hold_done;

   // ------------------------------------------------------------------------
   // Rectangle predictor
   // ------------------------------------------------------------------------

   // Wrapping extent test that orders axes for union, intersect and
   // rectangle containment.
   function automatic logic extent_negative(coord_type first, coord_type second);
      logic [CW-1:0] extent;
      extent = second - first + 1;
      return extent[CW-1];
   endfunction

   // Ordering test of normalize and point containment.
   function automatic logic below_minus_one(coord_type first, coord_type second);
      coord_type lower;
      lower = first - 1;
      return second < lower;
   endfunction

   function automatic logic is_null(coord_type l, coord_type t, coord_type r,
                                    coord_type b);
      coord_type l_less, t_less;
      l_less = l - 1;
      t_less = t - 1;
      return (r == l_less) && (b == t_less);
   endfunction

   function automatic void order_span(input coord_type first, input coord_type second,
                                      output coord_type lo, output coord_type hi);
      if (extent_negative(first, second)) begin
         lo = second;
         hi = first;
      end else begin
         lo = first;
         hi = second;
      end
   endfunction

   // One axis of the point test; no null check on the interval.
   function automatic logic axis_holds_point(coord_type first, coord_type second,
                                             coord_type p, logic strict);
      coord_type lo, hi;
      if (below_minus_one(first, second)) begin
         lo = second;
         hi = first;
      end else begin
         lo = first;
         hi = second;
      end
      if (strict)
         return (lo < p) && (p < hi);
      return !(p < lo) && !(hi < p);
   endfunction

   function automatic coord_type smin(coord_type x, coord_type y);
      return (y < x) ? y : x;
   endfunction

   function automatic coord_type smax(coord_type x, coord_type y);
      return (x < y) ? y : x;
   endfunction

   function automatic rect_rsp_type compute_rect_op(rect_req_type rq);
      rect_rsp_type rs;
      coord_type    l1, r1, t1, b1, l2, r2, t2, b2;
      logic         a_null, b_null, disjoint;
      rs = '{default: '0};
      a_null = is_null(rq.a_left, rq.a_top, rq.a_right, rq.a_bottom);
      b_null = is_null(rq.b_left, rq.b_top, rq.b_right, rq.b_bottom);
      case (rq.op)
         OP_NORMALIZE: begin
            if (below_minus_one(rq.a_left, rq.a_right)) begin
               rs.res_left  = rq.a_right;
               rs.res_right = rq.a_left;
            end else begin
               rs.res_left  = rq.a_left;
               rs.res_right = rq.a_right;
            end
            if (below_minus_one(rq.a_top, rq.a_bottom)) begin
               rs.res_top    = rq.a_bottom;
               rs.res_bottom = rq.a_top;
            end else begin
               rs.res_top    = rq.a_top;
               rs.res_bottom = rq.a_bottom;
            end
         end
         OP_CONTAINS_POINT: begin
            rs.answer = axis_holds_point(rq.a_left, rq.a_right, rq.b_left, rq.proper) &&
                        axis_holds_point(rq.a_top, rq.a_bottom, rq.b_top, rq.proper);
         end
         OP_UNION, OP_INTERSECT, OP_INTERSECTS, OP_CONTAINS_RECT: begin
            if (rq.op == OP_UNION && a_null) begin
               // A null A yields B as given, even when B is null too.
               rs.res_left   = rq.b_left;
               rs.res_top    = rq.b_top;
               rs.res_right  = rq.b_right;
               rs.res_bottom = rq.b_bottom;
            end else if (rq.op == OP_UNION && b_null) begin
               rs.res_left   = rq.a_left;
               rs.res_top    = rq.a_top;
               rs.res_right  = rq.a_right;
               rs.res_bottom = rq.a_bottom;
            end else if (rq.op != OP_UNION && (a_null || b_null)) begin
               if (rq.op == OP_INTERSECT) begin
                  rs.res_right  = -1;
                  rs.res_bottom = -1;
               end
            end else begin
               order_span(rq.a_left, rq.a_right, l1, r1);
               order_span(rq.b_left, rq.b_right, l2, r2);
               order_span(rq.a_top, rq.a_bottom, t1, b1);
               order_span(rq.b_top, rq.b_bottom, t2, b2);
               disjoint = (r2 < l1) || (r1 < l2) || (b2 < t1) || (b1 < t2);
               case (rq.op)
                  OP_UNION: begin
                     rs.res_left   = smin(l1, l2);
                     rs.res_top    = smin(t1, t2);
                     rs.res_right  = smax(r1, r2);
                     rs.res_bottom = smax(b1, b2);
                  end
                  OP_INTERSECT: begin
                     if (disjoint) begin
                        rs.res_right  = -1;
                        rs.res_bottom = -1;
                     end else begin
                        rs.res_left   = smax(l1, l2);
                        rs.res_top    = smax(t1, t2);
                        rs.res_right  = smin(r1, r2);
                        rs.res_bottom = smin(b1, b2);
                     end
                  end
                  OP_INTERSECTS: rs.answer = !disjoint;
                  default: begin
                     if (rq.proper)
                        rs.answer = (l1 < l2) && (r2 < r1) && (t1 < t2) && (b2 < b1);
                     else
                        rs.answer = !(l2 < l1) && !(r1 < r2) && !(t2 < t1) && !(b1 < b2);
                  end
               endcase
            end
         end
         default: ;
      endcase
      return rs;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic rect_req_type mk_req(logic [OP_WIDTH-1:0] op, logic strict,
                                           coord_type al, coord_type at,
                                           coord_type ar, coord_type ab,
                                           coord_type bl, coord_type bt,
                                           coord_type br, coord_type bb);
      rect_req_type rq;
      rq.op       = op;
      rq.proper   = strict;
      rq.a_left   = al;
      rq.a_top    = at;
      rq.a_right  = ar;
      rq.a_bottom = ab;
      rq.b_left   = bl;
      rq.b_top    = bt;
      rq.b_right  = br;
      rq.b_bottom = bb;
      return rq;
   endfunction

   // Mostly close to the center so rectangles overlap, touch and nest;
   // sometimes anywhere, sometimes at the ends of the range or at zero and minus one.
   function automatic coord_type near_coord(coord_type center);
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 60)
         return center + coord_type'($urandom_range(40)) - 20;
      if (sel < 75)
         return coord_type'($urandom);
      if (sel < 85) begin
         case ($urandom_range(5))
            0: return COORD_MIN;
            1: return COORD_MIN + 1;
            2: return COORD_MAX;
            3: return COORD_MAX - 1;
            4: return 0;
            default: return -1;
         endcase
      end
      return center + coord_type'($urandom_range(32'h000f_ffff)) - 32'sh0008_0000;
   endfunction

   function automatic rect_req_type random_req();
      logic [OP_WIDTH-1:0] op;
      coord_type           center, al, at, ar, ab, bl, bt, br, bb;
      if ($urandom_range(99) < 4)
         op = $urandom_range(1) ? OP_SPARE_7 : OP_SPARE_6;
      else
         op = OP_WIDTH'($urandom_range(5));
      if ($urandom_range(99) < 75)
         center = coord_type'($urandom_range(200)) - 100;
      else
         center = coord_type'($urandom);
      al = near_coord(center);
      at = near_coord(center);
      ar = near_coord(center);
      ab = near_coord(center);
      if ($urandom_range(99) < 10) begin
         ar = al - 1;
         ab = at - 1;
      end
      br = near_coord(center);
      bb = near_coord(center);
      if (op == OP_CONTAINS_POINT && $urandom_range(99) < 80) begin
         // Points on and around the corners of A.
         bl = ($urandom_range(1) ? al : ar) + coord_type'($urandom_range(4)) - 2;
         bt = ($urandom_range(1) ? at : ab) + coord_type'($urandom_range(4)) - 2;
      end else if ($urandom_range(99) < 30) begin
         // B close to A, so containment and touching edges come up often.
         bl = al + coord_type'($urandom_range(4)) - 2;
         bt = at + coord_type'($urandom_range(4)) - 2;
         br = ar + coord_type'($urandom_range(4)) - 2;
         bb = ab + coord_type'($urandom_range(4)) - 2;
      end else begin
         bl = near_coord(center);
         bt = near_coord(center);
      end
      if ($urandom_range(99) < 10) begin
         br = bl - 1;
         bb = bt - 1;
      end
      return mk_req(op, 1'($urandom_range(1)), al, at, ar, ab, bl, bt, br, bb);
   endfunction

   // Holds until every queued request is taken and every result has come.
   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_bus.valid || expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   task automatic check_field(string name, coord_type want, coord_type got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         failed = 1'b1;
      end
   endtask

   // ------------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Request driver: offers the next pending request after each transfer.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      rect_req_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (pending_reqs.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
            nxt = pending_reqs.pop_front();
            req_bus.op       <= nxt.op;
            req_bus.proper   <= nxt.proper;
            req_bus.a_left   <= nxt.a_left;
            req_bus.a_top    <= nxt.a_top;
            req_bus.a_right  <= nxt.a_right;
            req_bus.a_bottom <= nxt.a_bottom;
            req_bus.b_left   <= nxt.b_left;
            req_bus.b_top    <= nxt.b_top;
            req_bus.b_right  <= nxt.b_right;
            req_bus.b_bottom <= nxt.b_bottom;
            req_bus.valid    <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result receiver: random stalls plus one long hold-off that backs the
   // block up into its input.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles   <= hold_cycles - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!hold_done && req_count >= 400) begin
         hold_cycles   <= 150;
         hold_done     <= 1'b1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: checks each result transfer, then records the prediction for
   // each request transfer.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rect_req_type seen;
      rect_rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rsps.size() == 0) begin
               $error("result transfer with no request outstanding");
               failed = 1'b1;
            end else begin
               want = expected_rsps.pop_front();
               check_field("res_left", want.res_left, rsp_bus.res_left);
               check_field("res_top", want.res_top, rsp_bus.res_top);
               check_field("res_right", want.res_right, rsp_bus.res_right);
               check_field("res_bottom", want.res_bottom, rsp_bus.res_bottom);
               check_field("answer", coord_type'(want.answer),
                           coord_type'(rsp_bus.answer));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            seen = mk_req(req_bus.op, req_bus.proper,
                          req_bus.a_left, req_bus.a_top, req_bus.a_right, req_bus.a_bottom,
                          req_bus.b_left, req_bus.b_top, req_bus.b_right, req_bus.b_bottom);
            expected_rsps.push_back(compute_rect_op(seen));
            req_count++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------------
   initial begin
      #2_000_000;
      $display("FAIL rectangle_set_ops_unit");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus sequence
   // ------------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      no_idle          = 1'b0;
      failed           = 1'b0;
      req_count        = 0;
      hold_cycles      = 0;
      hold_done        = 1'b0;
      req_taken        = 1'b0;
      req_bus.valid    = 1'b0;
      req_bus.op       = '0;
      req_bus.proper   = 1'b0;
      req_bus.a_left   = '0;
      req_bus.a_top    = '0;
      req_bus.a_right  = '0;
      req_bus.a_bottom = '0;
      req_bus.b_left   = '0;
      req_bus.b_top    = '0;
      req_bus.b_right  = '0;
      req_bus.b_bottom = '0;
      rsp_bus.ready    = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Normalize: flipped axes, a null rectangle, and both ends of the range.
      pending_reqs.push_back(mk_req(OP_NORMALIZE, 1'b0, 10, 20, 5, 3, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(OP_NORMALIZE, 1'b1, 5, 5, 4, 4, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(OP_NORMALIZE, 1'b0, COORD_MAX, COORD_MAX,
                                    COORD_MIN, COORD_MIN, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(OP_NORMALIZE, 1'b0, COORD_MIN, COORD_MIN,
                                    COORD_MAX, COORD_MAX, 0, 0, 0, 0));
      // Union: null A, null B, both null, flipped A, an extent that wraps.
      pending_reqs.push_back(mk_req(OP_UNION, 1'b0, 3, 3, 2, 2, 1, 2, 30, 40));
      pending_reqs.push_back(mk_req(OP_UNION, 1'b0, -5, -6, 7, 8, 0, 0, -1, -1));
      pending_reqs.push_back(mk_req(OP_UNION, 1'b1, 0, 0, -1, -1, 9, 9, 8, 8));
      pending_reqs.push_back(mk_req(OP_UNION, 1'b0, 10, 10, 0, 0, -3, 5, 4, 20));
      pending_reqs.push_back(mk_req(OP_UNION, 1'b0, 0, 0, COORD_MAX, COORD_MAX,
                                    1, 1, 2, 2));
      // Intersect: overlap, disjoint, null operand, touching corners.
      pending_reqs.push_back(mk_req(OP_INTERSECT, 1'b0, 0, 0, 10, 10, 5, 5, 20, 20));
      pending_reqs.push_back(mk_req(OP_INTERSECT, 1'b0, 0, 0, 3, 3, 5, 5, 8, 8));
      pending_reqs.push_back(mk_req(OP_INTERSECT, 1'b0, 0, 0, 10, 10, 7, 7, 6, 6));
      pending_reqs.push_back(mk_req(OP_INTERSECT, 1'b1, 0, 0, 5, 5, 5, 5, 9, 9));
      // Intersects: true, false, null operand.
      pending_reqs.push_back(mk_req(OP_INTERSECTS, 1'b0, 0, 0, 10, 10, 10, 10, 12, 12));
      pending_reqs.push_back(mk_req(OP_INTERSECTS, 1'b0, 0, 0, 10, 10, 11, 0, 12, 10));
      pending_reqs.push_back(mk_req(OP_INTERSECTS, 1'b0, 4, 4, 3, 3, 0, 0, 10, 10));
      // Contains rectangle: equal edges with and without strict bounds, null B.
      pending_reqs.push_back(mk_req(OP_CONTAINS_RECT, 1'b0, 0, 0, 10, 10, 0, 0, 10, 10));
      pending_reqs.push_back(mk_req(OP_CONTAINS_RECT, 1'b1, 0, 0, 10, 10, 0, 0, 10, 10));
      pending_reqs.push_back(mk_req(OP_CONTAINS_RECT, 1'b1, 10, 10, 0, 0, 1, 1, 9, 9));
      pending_reqs.push_back(mk_req(OP_CONTAINS_RECT, 1'b0, 0, 0, 10, 10, 5, 5, 4, 4));
      // Contains point: on the edge, strict, against a null rectangle, full range.
      pending_reqs.push_back(mk_req(OP_CONTAINS_POINT, 1'b0, 0, 0, 10, 10, 10, 5, 0, 0));
      pending_reqs.push_back(mk_req(OP_CONTAINS_POINT, 1'b1, 0, 0, 10, 10, 10, 5, 0, 0));
      pending_reqs.push_back(mk_req(OP_CONTAINS_POINT, 1'b0, 5, 5, 4, 4, 4, 4, 0, 0));
      pending_reqs.push_back(mk_req(OP_CONTAINS_POINT, 1'b0, COORD_MIN, COORD_MIN,
                                    COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, 0, 0));
      // Unused op codes give an all-zero result.
      pending_reqs.push_back(mk_req(OP_SPARE_6, 1'b1, 1, 2, 3, 4, 5, 6, 7, 8));
      pending_reqs.push_back(mk_req(OP_SPARE_7, 1'b1, -1, -1, -1, -1, -1, -1, -1, -1));

      // The sender pauses here until every directed result is back.
      wait_drained();

      // Random traffic in three stretches; the middle one runs without gaps.
      for (int i = 0; i < 800; i++)
         pending_reqs.push_back(random_req());
      wait_drained();
      no_idle = 1'b1;
      for (int i = 0; i < 400; i++)
         pending_reqs.push_back(random_req());
      wait_drained();
      no_idle = 1'b0;
      for (int i = 0; i < RANDOM_ITEMS - 1200; i++)
         pending_reqs.push_back(random_req());
      wait_drained();

      // Let any stray result show up before the verdict.
      repeat (10) @(posedge clock);
      if (!failed)
         $display("PASS rectangle_set_ops_unit");
      else
         $display("FAIL rectangle_set_ops_unit");
      $finish;
   end

endmodule
